[design/ppe_pkg.sv]
// ----------------------------------------------------------------------------
// ppe_pkg: shared definitions for the pattern password enumerator
// constants, command types and small helper functions
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

    localparam int MAX_LEN   = 16;
    localparam int MAX_SET   = 128;
    localparam int LEN_CAP   = (MAX_LEN < 16) ? MAX_LEN : 16;
    localparam int POS_W     = 4;
    localparam int LEN_W     = 5;
    localparam int IDX_W     = $clog2(MAX_SET);
    localparam int SIZE_W    = $clog2(MAX_SET + 1);
    localparam int ADDR_W    = POS_W + IDX_W;
    localparam int MEM_DEPTH = LEN_CAP * MAX_SET;
    localparam int DOT_COUNT = 62;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_NEXT = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNCLOSED   = 3'd1;
    localparam logic [2:0] ST_TOO_FEW    = 3'd2;
    localparam logic [2:0] ST_TOO_MANY   = 3'd3;
    localparam logic [2:0] ST_DASH       = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd6;
    localparam logic [2:0] ST_NOT_LOADED = 3'd7;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_NEXT
    } kind_t;

    typedef enum logic [2:0] {
        CLS_PLAIN,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_DASH,
        CLS_DOT
    } class_t;

    typedef struct packed {
        kind_t      kind;
        class_t     cls;
        logic [7:0] data;
    } cmd_t;

    // a-z, A-Z, 0-9
    function automatic logic [7:0] dot_char(input logic [5:0] i);
        logic [7:0] w;
        w = {2'b00, i};
        if (i < 6'd26)
            return 8'h61 + w;
        else if (i < 6'd52)
            return 8'h41 + w - 8'd26;
        else
            return 8'h30 + w - 8'd52;
    endfunction

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
        if (n == '0)
            return LEN_W'(1);
        else if (n > LEN_W'(LEN_CAP))
            return LEN_W'(LEN_CAP);
        else
            return n;
    endfunction

endpackage

`default_nettype wire

[design/ppe_if.sv]
// ----------------------------------------------------------------------------
// ppe channel interfaces
// command channel into the enumerator and result channel out of it
// ----------------------------------------------------------------------------
`default_nettype none

interface ppe_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] pattern_byte;

    modport source (output valid, output operation, output pattern_byte, input ready);
    modport sink (input valid, input operation, input pattern_byte, output ready);
endinterface

interface ppe_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] position;
    logic [7:0] character;
    logic [2:0] status_code;
    logic [4:0] changed_count;
    logic       last_result;

    modport source (output valid, output position, output character, output status_code,
                    output changed_count, output last_result, input ready);
    modport sink (input valid, input position, input character, input status_code,
                  input changed_count, input last_result, output ready);
endinterface

`default_nettype wire

[design/ppe_front.sv]
// ----------------------------------------------------------------------------
// ppe_front: command intake
// accepts command beats, drops unused codes and classifies pattern bytes
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_front (
    ppe_cmd_if.sink        cmd,
    input  wire logic      q_full,
    output logic           push,
    output ppe_pkg::cmd_t  push_data
);

    assign cmd.ready = !q_full;
    assign push      = cmd.valid && !q_full &&
                       (cmd.operation == ppe_pkg::OP_BYTE ||
                        cmd.operation == ppe_pkg::OP_END  ||
                        cmd.operation == ppe_pkg::OP_NEXT);

    always_comb
    begin
        push_data.data = cmd.pattern_byte;
        priority if (cmd.operation == ppe_pkg::OP_END)
            push_data.kind = ppe_pkg::KIND_END;
        else if (cmd.operation == ppe_pkg::OP_NEXT)
            push_data.kind = ppe_pkg::KIND_NEXT;
        else
            push_data.kind = ppe_pkg::KIND_BYTE;

        priority if (cmd.pattern_byte == ppe_pkg::CH_OPEN)
            push_data.cls = ppe_pkg::CLS_OPEN;
        else if (cmd.pattern_byte == ppe_pkg::CH_CLOSE)
            push_data.cls = ppe_pkg::CLS_CLOSE;
        else if (cmd.pattern_byte == ppe_pkg::CH_DASH)
            push_data.cls = ppe_pkg::CLS_DASH;
        else if (cmd.pattern_byte == ppe_pkg::CH_DOT)
            push_data.cls = ppe_pkg::CLS_DOT;
        else
            push_data.cls = ppe_pkg::CLS_PLAIN;
    end

endmodule

`default_nettype wire

[design/ppe_queue.sv]
// ----------------------------------------------------------------------------
// ppe_queue: two-entry command queue
// decouples command intake from execution
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ppe_pkg::cmd_t  push_data,
    output logic                full,
    input  wire logic           pop,
    output ppe_pkg::cmd_t       pop_data,
    output logic                empty
);

    ppe_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

[design/ppe_back.sv]
// ----------------------------------------------------------------------------
// ppe_back: command execution
// builds the per-position sets, loads the candidate and steps the odometer
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire ppe_pkg::cmd_t                q_data,
    output logic                              q_pop,
    input  wire logic [ppe_pkg::LEN_W-1:0]    password_length,
    ppe_res_if.source                         result
);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_SET,
        MODE_RANGE
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE,
        S_FILL,
        S_END,
        S_NEXT,
        S_WALK,
        S_RD,
        S_WR,
        S_STAT
    } state_t;

    state_t                        state_reg;
    ppe_pkg::cmd_t                 cur_reg;
    mode_t                         mode_reg;
    logic [ppe_pkg::LEN_W-1:0]     wp_reg;
    logic [7:0]                    range_start_reg;
    logic [7:0]                    last_char_reg;
    logic [2:0]                    err_reg;
    logic                          loaded_reg;
    logic                          exh_reg;
    logic [ppe_pkg::SIZE_W-1:0]    set_size_reg [ppe_pkg::LEN_CAP];
    logic [ppe_pkg::IDX_W-1:0]     char_index_reg [ppe_pkg::LEN_CAP];
    logic [7:0]                    fill_val_reg;
    logic [7:0]                    fill_cnt_reg;
    logic                          fill_dot_reg;
    logic                          fill_up_reg;
    logic [ppe_pkg::POS_W-1:0]     cur_pos_reg;
    logic [ppe_pkg::POS_W-1:0]     pend_pos_reg;
    logic                          pend_last_reg;
    logic [ppe_pkg::LEN_W-1:0]     pend_cnt_reg;
    logic [2:0]                    pend_status_reg;
    logic                          load_mode_reg;
    logic [ppe_pkg::ADDR_W-1:0]    rd_addr_reg;
    logic [7:0]                    rd_data_reg;

    logic                          out_valid_reg;
    logic [3:0]                    out_pos_reg;
    logic [7:0]                    out_char_reg;
    logic [2:0]                    out_status_reg;
    logic [4:0]                    out_cnt_reg;
    logic                          out_last_reg;

    logic [7:0]                    mem [ppe_pkg::MEM_DEPTH];

    logic [ppe_pkg::POS_W-1:0]     sel_pos;
    logic [ppe_pkg::SIZE_W-1:0]    size_sel;
    logic [ppe_pkg::IDX_W-1:0]     idx_sel;
    logic                          size_full;
    logic                          idx_at_end;
    logic [ppe_pkg::LEN_W-1:0]     plen;
    logic [ppe_pkg::LEN_W-1:0]     nlen;
    logic                          any_room;
    logic                          app_we;
    logic                          app_over;
    logic [ppe_pkg::IDX_W-1:0]     app_idx;
    logic [7:0]                    app_char;
    logic [2:0]                    end_status;
    logic                          out_free;
    logic                          out_load;
    logic                          byte_fill;
    logic [ppe_pkg::POS_W-1:0]     load_next_pos;

    assign result.valid         = out_valid_reg;
    assign result.position      = out_pos_reg;
    assign result.character     = out_char_reg;
    assign result.status_code   = out_status_reg;
    assign result.changed_count = out_cnt_reg;
    assign result.last_result   = out_last_reg;

    assign out_free = !out_valid_reg || result.ready;
    assign out_load = out_free && (state_reg == S_WR || state_reg == S_STAT);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    assign sel_pos    = (state_reg == S_WALK) ? cur_pos_reg : wp_reg[ppe_pkg::POS_W-1:0];
    assign size_sel   = set_size_reg[sel_pos];
    assign idx_sel    = char_index_reg[sel_pos];
    assign size_full  = (size_sel >= ppe_pkg::SIZE_W'(ppe_pkg::MAX_SET));
    assign idx_at_end = ({1'b0, idx_sel} + 1'b1 >= size_sel);
    assign plen       = ppe_pkg::eff_len(password_length);
    assign nlen       = (wp_reg == '0 || wp_reg > ppe_pkg::LEN_W'(ppe_pkg::LEN_CAP)) ?
                        ppe_pkg::LEN_W'(1) : wp_reg;
    assign load_next_pos = pend_pos_reg + 1'b1;

    // pattern byte that needs the multi-cycle fill (dot or two-ended range)
    assign byte_fill = (err_reg == ppe_pkg::ST_OK) && (wp_reg < plen) &&
                       ((mode_reg == MODE_NORMAL && cur_reg.cls == ppe_pkg::CLS_DOT) ||
                        (mode_reg == MODE_RANGE && range_start_reg != cur_reg.data));

    // any active position that can still advance
    always_comb
    begin
        any_room = 1'b0;
        for (int p = 0; p < ppe_pkg::LEN_CAP; p++)
        begin
            if (ppe_pkg::LEN_W'(p) < nlen &&
                ({1'b0, char_index_reg[p]} + 1'b1 < set_size_reg[p]))
                any_room = 1'b1;
        end
    end

    always_comb
    begin
        if (err_reg != ppe_pkg::ST_OK)
            end_status = err_reg;
        else if (mode_reg != MODE_NORMAL)
            end_status = ppe_pkg::ST_UNCLOSED;
        else if (wp_reg < plen)
            end_status = ppe_pkg::ST_TOO_FEW;
        else if (wp_reg > plen)
            end_status = ppe_pkg::ST_TOO_MANY;
        else
            end_status = ppe_pkg::ST_OK;
    end

    // one set append per cycle at most
    always_comb
    begin
        app_we   = 1'b0;
        app_over = 1'b0;
        app_idx  = size_sel[ppe_pkg::IDX_W-1:0];
        app_char = cur_reg.data;
        if (state_reg == S_BYTE && err_reg == ppe_pkg::ST_OK && wp_reg < plen)
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (cur_reg.cls != ppe_pkg::CLS_OPEN && cur_reg.cls != ppe_pkg::CLS_DOT)
                    begin
                        app_we  = 1'b1;
                        app_idx = '0;
                    end
                end
                MODE_SET:
                begin
                    if (cur_reg.cls == ppe_pkg::CLS_CLOSE)
                    begin
                        if (size_sel == '0)
                        begin
                            app_we   = 1'b1;
                            app_idx  = '0;
                            app_char = 8'h00;
                        end
                    end
                    else if (cur_reg.cls != ppe_pkg::CLS_DASH)
                    begin
                        app_over = size_full;
                        app_we   = !size_full;
                    end
                end
                MODE_RANGE:
                begin
                    if (range_start_reg == cur_reg.data)
                    begin
                        app_over = size_full;
                        app_we   = !size_full;
                    end
                end
                default:
                begin
                    app_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_FILL)
        begin
            app_over = size_full;
            app_we   = !size_full;
            app_char = fill_dot_reg ? ppe_pkg::dot_char(fill_val_reg[5:0]) : fill_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_we)
            mem[{sel_pos, app_idx}] <= app_char;
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_reg         <= '0;
            mode_reg        <= MODE_NORMAL;
            wp_reg          <= '0;
            range_start_reg <= '0;
            last_char_reg   <= '0;
            err_reg         <= ppe_pkg::ST_OK;
            loaded_reg      <= 1'b0;
            exh_reg         <= 1'b0;
            for (int p = 0; p < ppe_pkg::LEN_CAP; p++)
            begin
                set_size_reg[p]   <= '0;
                char_index_reg[p] <= '0;
            end
            fill_val_reg    <= '0;
            fill_cnt_reg    <= '0;
            fill_dot_reg    <= 1'b0;
            fill_up_reg     <= 1'b0;
            cur_pos_reg     <= '0;
            pend_pos_reg    <= '0;
            pend_last_reg   <= 1'b0;
            pend_cnt_reg    <= '0;
            pend_status_reg <= ppe_pkg::ST_OK;
            load_mode_reg   <= 1'b0;
            rd_addr_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_pos_reg     <= '0;
            out_char_reg    <= '0;
            out_status_reg  <= ppe_pkg::ST_OK;
            out_cnt_reg     <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg <= q_data;
                        if (q_data.kind != ppe_pkg::KIND_NEXT && loaded_reg)
                        begin
                            // a new pattern drops the loaded one
                            loaded_reg      <= 1'b0;
                            exh_reg         <= 1'b0;
                            mode_reg        <= MODE_NORMAL;
                            wp_reg          <= '0;
                            range_start_reg <= '0;
                            err_reg         <= ppe_pkg::ST_OK;
                        end
                        unique case (q_data.kind)
                            ppe_pkg::KIND_BYTE: state_reg <= S_BYTE;
                            ppe_pkg::KIND_END:  state_reg <= S_END;
                            ppe_pkg::KIND_NEXT: state_reg <= S_NEXT;
                            default:            state_reg <= S_IDLE;
                        endcase
                    end
                end

                S_BYTE:
                begin
                    state_reg <= byte_fill ? S_FILL : S_IDLE;
                    if (err_reg == ppe_pkg::ST_OK && wp_reg >= plen)
                    begin
                        err_reg <= ppe_pkg::ST_TOO_MANY;
                    end
                    else if (err_reg == ppe_pkg::ST_OK)
                    begin
                        unique case (mode_reg)
                            MODE_NORMAL:
                            begin
                                if (cur_reg.cls == ppe_pkg::CLS_OPEN)
                                begin
                                    set_size_reg[sel_pos] <= '0;
                                    mode_reg              <= MODE_SET;
                                end
                                else if (cur_reg.cls == ppe_pkg::CLS_DOT)
                                begin
                                    set_size_reg[sel_pos] <= '0;
                                    fill_val_reg <= '0;
                                    fill_cnt_reg <= 8'(ppe_pkg::DOT_COUNT);
                                    fill_dot_reg <= 1'b1;
                                    fill_up_reg  <= 1'b1;
                                end
                                else
                                begin
                                    set_size_reg[sel_pos] <= ppe_pkg::SIZE_W'(1);
                                    wp_reg                <= wp_reg + 1'b1;
                                end
                            end
                            MODE_SET:
                            begin
                                if (cur_reg.cls == ppe_pkg::CLS_CLOSE)
                                begin
                                    if (size_sel == '0)
                                        set_size_reg[sel_pos] <= ppe_pkg::SIZE_W'(1);
                                    mode_reg <= MODE_NORMAL;
                                    wp_reg   <= wp_reg + 1'b1;
                                end
                                else if (cur_reg.cls == ppe_pkg::CLS_DASH)
                                begin
                                    if (size_sel == '0)
                                        err_reg <= ppe_pkg::ST_DASH;
                                    else
                                    begin
                                        range_start_reg <= last_char_reg;
                                        mode_reg        <= MODE_RANGE;
                                    end
                                end
                                else if (app_over)
                                    err_reg <= ppe_pkg::ST_OVERFLOW;
                                else
                                begin
                                    set_size_reg[sel_pos] <= size_sel + 1'b1;
                                    last_char_reg         <= cur_reg.data;
                                end
                            end
                            MODE_RANGE:
                            begin
                                if (range_start_reg < cur_reg.data)
                                begin
                                    fill_val_reg <= range_start_reg + 8'd1;
                                    fill_cnt_reg <= cur_reg.data - range_start_reg;
                                    fill_dot_reg <= 1'b0;
                                    fill_up_reg  <= 1'b1;
                                end
                                else if (range_start_reg > cur_reg.data)
                                begin
                                    fill_val_reg <= range_start_reg - 8'd1;
                                    fill_cnt_reg <= range_start_reg - cur_reg.data;
                                    fill_dot_reg <= 1'b0;
                                    fill_up_reg  <= 1'b0;
                                end
                                else if (app_over)
                                    err_reg <= ppe_pkg::ST_OVERFLOW;
                                else
                                begin
                                    set_size_reg[sel_pos] <= size_sel + 1'b1;
                                    last_char_reg         <= cur_reg.data;
                                    mode_reg              <= MODE_SET;
                                end
                            end
                            default:
                            begin
                                mode_reg <= MODE_NORMAL;
                            end
                        endcase
                    end
                end

                S_FILL:
                begin
                    if (app_over)
                    begin
                        err_reg   <= ppe_pkg::ST_OVERFLOW;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        set_size_reg[sel_pos] <= size_sel + 1'b1;
                        last_char_reg         <= app_char;
                        fill_val_reg <= fill_up_reg ? fill_val_reg + 8'd1 : fill_val_reg - 8'd1;
                        fill_cnt_reg <= fill_cnt_reg - 8'd1;
                        if (fill_cnt_reg == 8'd1)
                        begin
                            if (fill_dot_reg)
                                wp_reg <= wp_reg + 1'b1;
                            else
                                mode_reg <= MODE_SET;
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_END:
                begin
                    if (end_status != ppe_pkg::ST_OK)
                    begin
                        mode_reg        <= MODE_NORMAL;
                        wp_reg          <= '0;
                        range_start_reg <= '0;
                        err_reg         <= ppe_pkg::ST_OK;
                        pend_status_reg <= end_status;
                        state_reg       <= S_STAT;
                    end
                    else
                    begin
                        loaded_reg <= 1'b1;
                        exh_reg    <= 1'b0;
                        for (int p = 0; p < ppe_pkg::LEN_CAP; p++)
                            char_index_reg[p] <= '0;
                        load_mode_reg <= 1'b1;
                        pend_pos_reg  <= '0;
                        pend_last_reg <= (plen == ppe_pkg::LEN_W'(1));
                        pend_cnt_reg  <= (plen == ppe_pkg::LEN_W'(1)) ? plen : '0;
                        rd_addr_reg   <= '0;
                        state_reg     <= S_RD;
                    end
                end

                S_NEXT:
                begin
                    if (!loaded_reg)
                    begin
                        pend_status_reg <= ppe_pkg::ST_NOT_LOADED;
                        state_reg       <= S_STAT;
                    end
                    else if (exh_reg || !any_room)
                    begin
                        exh_reg         <= 1'b1;
                        pend_status_reg <= ppe_pkg::ST_EXHAUSTED;
                        state_reg       <= S_STAT;
                    end
                    else
                    begin
                        load_mode_reg <= 1'b0;
                        cur_pos_reg   <= ppe_pkg::POS_W'(nlen - 1'b1);
                        pend_cnt_reg  <= '0;
                        state_reg     <= S_WALK;
                    end
                end

                S_WALK:
                begin
                    pend_pos_reg <= cur_pos_reg;
                    state_reg    <= S_RD;
                    if (idx_at_end && cur_pos_reg != '0)
                    begin
                        // wrap this digit and carry into the next one down
                        char_index_reg[cur_pos_reg] <= '0;
                        rd_addr_reg   <= {cur_pos_reg, {ppe_pkg::IDX_W{1'b0}}};
                        pend_last_reg <= 1'b0;
                        cur_pos_reg   <= cur_pos_reg - 1'b1;
                    end
                    else
                    begin
                        char_index_reg[cur_pos_reg] <= idx_sel + 1'b1;
                        rd_addr_reg   <= {cur_pos_reg, idx_sel + 1'b1};
                        pend_last_reg <= 1'b1;
                    end
                end

                S_RD:
                begin
                    state_reg <= S_WR;
                end

                S_WR:
                begin
                    if (out_free)
                    begin
                        out_pos_reg    <= pend_pos_reg;
                        out_char_reg   <= rd_data_reg;
                        out_status_reg <= ppe_pkg::ST_OK;
                        out_last_reg   <= pend_last_reg;
                        if (load_mode_reg)
                            out_cnt_reg <= pend_cnt_reg;
                        else
                            out_cnt_reg <= pend_last_reg ? pend_cnt_reg + 1'b1 : '0;

                        if (pend_last_reg)
                            state_reg <= S_IDLE;
                        else if (load_mode_reg)
                        begin
                            pend_pos_reg  <= load_next_pos;
                            pend_last_reg <= ({1'b0, load_next_pos} + 1'b1 == wp_reg);
                            pend_cnt_reg  <= ({1'b0, load_next_pos} + 1'b1 == wp_reg) ?
                                             wp_reg : '0;
                            rd_addr_reg   <= {load_next_pos, {ppe_pkg::IDX_W{1'b0}}};
                            state_reg     <= S_RD;
                        end
                        else
                        begin
                            pend_cnt_reg <= pend_cnt_reg + 1'b1;
                            state_reg    <= S_WALK;
                        end
                    end
                end

                S_STAT:
                begin
                    if (out_free)
                    begin
                        out_pos_reg    <= '0;
                        out_char_reg   <= '0;
                        out_status_reg <= pend_status_reg;
                        out_cnt_reg    <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/pattern_password_enumerator.sv]
// ----------------------------------------------------------------------------
// pattern_password_enumerator: password candidate generator
// per-position character sets from a pattern, stepped as a mixed-radix counter
// ----------------------------------------------------------------------------
// Command beats carry an operation and a pattern byte. Pattern bytes build one
// character set per position (literal, '.' for the 62 letters and digits,
// bracketed lists with ascending or descending dash ranges); end of pattern
// checks the position count against password_length and returns either one
// status beat or the first candidate, one result beat per position; each next
// request returns the wrapped positions from the last one down, then the one
// that advanced, or a single exhausted / not-loaded status beat. A '.' or a
// two-ended range appends its characters one at a time in a fill state, since
// each set entry is written through the single set-store port. For each result
// beat a next request passes through a position walk, a registered read and
// the output register, after the pop and check; a load, after the pop and
// check, passes each position beat through the registered read and the output
// register. A held result beat stalls execution until it is taken.
// Commands queue two deep ahead of execution so intake keeps running while
// results are held.
// There is no clearing pass after reset; a never-written set entry is never
// read. Write password_length only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_password_enumerator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ppe_cmd_if.sink          cmd,
    ppe_res_if.source        result,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_data
);

    // length register, reset to one position
    logic [ppe_pkg::LEN_W-1:0] len_reg;

    // intake to queue
    logic          q_push;
    ppe_pkg::cmd_t q_push_data;
    logic          q_full;

    // queue to execution
    logic          q_pop;
    ppe_pkg::cmd_t q_pop_data;
    logic          q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= ppe_pkg::LEN_W'(1);
        else if (cfg_we)
            len_reg <= cfg_data;
    end

    // front: accept and classify command beats
    ppe_front u_front (
        .cmd       (cmd),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // short queue so both halves stall on their own
    ppe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // back: set building, candidate load and odometer stepping
    ppe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_pop_data),
        .q_pop           (q_pop),
        .password_length (len_reg),
        .result          (result)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

    // a status beat is always a lone final beat at position zero with no changed count
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status_code != ppe_pkg::ST_OK) |->
        (result.last_result && result.changed_count == 5'd0 && result.position == 4'd0))
        else $error("malformed status beat");

    // a good final beat reports at least one changed position
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.last_result && result.status_code == ppe_pkg::ST_OK) |->
        (result.changed_count != 5'd0))
        else $error("final beat with zero changed count");

endmodule

`default_nettype wire

[tb/sv/pattern_password_enumerator_tb.sv]
// ----------------------------------------------------------------------------
// pattern_password_enumerator_tb: self-checking bench for the enumerator
// drives pattern, end and next beats with random stalls on both channels,
// predicts every result beat in a behavioral model and compares field by field
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_password_enumerator_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 400;   // longest range expansion plus result pipe

    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_SET,
        PM_RANGE
    } pmode_t;

    typedef struct packed {
        logic [3:0] position;
        logic [7:0] character;
        logic [2:0] status_code;
        logic [4:0] changed_count;
        logic       last_result;
    } res_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_data;

    ppe_cmd_if cmd ();
    ppe_res_if result ();

    pattern_password_enumerator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // shadow state of the enumerator
    // ------------------------------------------------------------------------
    logic [7:0] sh_chars [ppe_pkg::LEN_CAP][ppe_pkg::MAX_SET];
    int         sh_size [ppe_pkg::LEN_CAP];
    int         sh_idx [ppe_pkg::LEN_CAP];
    pmode_t     sh_mode;
    int         sh_wpos;
    logic [7:0] sh_rstart;
    logic [2:0] sh_err;
    bit         sh_loaded;
    bit         sh_exhausted;
    logic [4:0] sh_len_reg;

    res_beat_t  expected_beats [$];

    int  n_errors;
    int  n_shown;
    bit  quiet;        // no idling on either side in the final part
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int len_now();
        int n;
        n = sh_len_reg;
        if (n < 1) n = 1;
        if (n > ppe_pkg::LEN_CAP) n = ppe_pkg::LEN_CAP;
        return n;
    endfunction

    function automatic logic [7:0] letter_or_digit(int i);
        if (i < 26) return 8'h61 + 8'(i);
        if (i < 52) return 8'h41 + 8'(i - 26);
        return 8'h30 + 8'(i - 52);
    endfunction

    function automatic bit add_char(int p, logic [7:0] c);
        if (sh_size[p] >= ppe_pkg::MAX_SET)
        begin
            sh_err = ppe_pkg::ST_OVERFLOW;
            return 1'b0;
        end
        sh_chars[p][sh_size[p]] = c;
        sh_size[p]++;
        return 1'b1;
    endfunction

    function automatic void reset_parser();
        sh_mode = PM_NORMAL;
        sh_wpos = 0;
        sh_rstart = '0;
        sh_err = ppe_pkg::ST_OK;
    endfunction

    function automatic void push_beat(int p, logic [7:0] c, logic [2:0] st, int cnt, bit last);
        res_beat_t b;
        b.position = 4'(p);
        b.character = c;
        b.status_code = st;
        b.changed_count = 5'(cnt);
        b.last_result = last;
        expected_beats.push_back(b);
    endfunction

    // one pattern byte into the set builder
    function automatic void build_sets(logic [7:0] c);
        int p;
        int i;
        p = sh_wpos;
        if (sh_err != ppe_pkg::ST_OK) return;
        if (p >= len_now())
        begin
            sh_err = ppe_pkg::ST_TOO_MANY;
            return;
        end
        case (sh_mode)
            PM_NORMAL:
            begin
                sh_size[p] = 0;
                if (c == ppe_pkg::CH_OPEN)
                    sh_mode = PM_SET;
                else if (c == ppe_pkg::CH_DOT)
                begin
                    for (i = 0; i < ppe_pkg::DOT_COUNT; i++)
                        if (!add_char(p, letter_or_digit(i))) return;
                    sh_wpos = p + 1;
                end
                else
                begin
                    void'(add_char(p, c));
                    sh_wpos = p + 1;
                end
            end
            PM_SET:
            begin
                if (c == ppe_pkg::CH_CLOSE)
                begin
                    if (sh_size[p] == 0) void'(add_char(p, 8'h00));
                    sh_mode = PM_NORMAL;
                    sh_wpos = p + 1;
                end
                else if (c == ppe_pkg::CH_DASH)
                begin
                    if (sh_size[p] == 0)
                    begin
                        sh_err = ppe_pkg::ST_DASH;
                        return;
                    end
                    sh_rstart = sh_chars[p][sh_size[p] - 1];
                    sh_mode = PM_RANGE;
                end
                else
                    void'(add_char(p, c));
            end
            default:
            begin
                // range end: ascending, descending, or equal ends adds once
                if (sh_rstart < c)
                begin
                    for (i = int'(sh_rstart) + 1; i <= int'(c); i++)
                        if (!add_char(p, 8'(i))) return;
                end
                else if (sh_rstart > c)
                begin
                    for (i = int'(sh_rstart); i > int'(c); i--)
                        if (!add_char(p, 8'(i - 1))) return;
                end
                else
                    void'(add_char(p, c));
                sh_mode = PM_SET;
            end
        endcase
    endfunction

    // expected result beats of one accepted command beat
    function automatic void predict_beats(logic [1:0] op, logic [7:0] c);
        int n;
        int p;
        int k;
        bit all_last;
        logic [2:0] st;
        if (op == ppe_pkg::OP_BYTE || op == ppe_pkg::OP_END)
        begin
            if (sh_loaded)
            begin
                sh_loaded = 1'b0;
                sh_exhausted = 1'b0;
                reset_parser();
            end
        end
        if (op == ppe_pkg::OP_BYTE)
            build_sets(c);
        else if (op == ppe_pkg::OP_END)
        begin
            n = len_now();
            if (sh_err != ppe_pkg::ST_OK) st = sh_err;
            else if (sh_mode != PM_NORMAL) st = ppe_pkg::ST_UNCLOSED;
            else if (sh_wpos < n) st = ppe_pkg::ST_TOO_FEW;
            else if (sh_wpos > n) st = ppe_pkg::ST_TOO_MANY;
            else st = ppe_pkg::ST_OK;
            if (st != ppe_pkg::ST_OK)
            begin
                reset_parser();
                push_beat(0, 8'h00, st, 0, 1'b1);
                return;
            end
            sh_loaded = 1'b1;
            sh_exhausted = 1'b0;
            for (p = 0; p < ppe_pkg::LEN_CAP; p++) sh_idx[p] = 0;
            for (p = 0; p < n; p++)
                push_beat(p, sh_chars[p][0], ppe_pkg::ST_OK, (p + 1 == n) ? n : 0,
                          p + 1 == n);
        end
        else if (op == ppe_pkg::OP_NEXT)
        begin
            if (!sh_loaded)
            begin
                push_beat(0, 8'h00, ppe_pkg::ST_NOT_LOADED, 0, 1'b1);
                return;
            end
            n = sh_wpos;
            if (n < 1 || n > ppe_pkg::LEN_CAP) n = 1;
            if (!sh_exhausted)
            begin
                all_last = 1'b1;
                for (p = 0; p < n; p++)
                    if (sh_idx[p] + 1 < sh_size[p]) all_last = 1'b0;
                sh_exhausted = all_last;
            end
            if (sh_exhausted)
            begin
                push_beat(0, 8'h00, ppe_pkg::ST_EXHAUSTED, 0, 1'b1);
                return;
            end
            // odometer step from the last position, wrapped digits first
            k = 0;
            p = n - 1;
            while (sh_idx[p] + 1 >= sh_size[p] && p > 0)
            begin
                sh_idx[p] = 0;
                push_beat(p, sh_chars[p][0], ppe_pkg::ST_OK, 0, 1'b0);
                k++;
                p--;
            end
            sh_idx[p]++;
            push_beat(p, sh_chars[p][sh_idx[p]], ppe_pkg::ST_OK, k + 1, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    int cmd_gap_left;

    task automatic send_beat(logic [1:0] op, logic [7:0] c);
        int gap;
        gap = 0;
        if (!quiet && cmd_gap_left == 0 && $urandom_range(0, 5) == 0)
            cmd_gap_left = $urandom_range(1, 15);
        if (cmd_gap_left > 0)
        begin
            gap = cmd_gap_left;
            cmd_gap_left = 0;
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.operation <= op;
        cmd.pattern_byte <= c;
        // inputs change only at the rising edge, so the value at the falling
        // edge is what the next rising edge sees
        forever
        begin
            @(negedge clk);
            if (cmd.ready) break;
        end
        predict_beats(op, c);
        @(posedge clk);
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) send_beat(ppe_pkg::OP_BYTE, s[i]);
    endtask

    task automatic wait_idle();
        cmd.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(logic [4:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_len_reg = v;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall bursts on ready, compare at the falling edge
    // ------------------------------------------------------------------------
    int stall_left;

    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    always @(negedge clk)
    begin
        res_beat_t got;
        res_beat_t want;
        if (rst_n && result.valid && result.ready)
        begin
            got.position = result.position;
            got.character = result.character;
            got.status_code = result.status_code;
            got.changed_count = result.changed_count;
            got.last_result = result.last_result;
            if (expected_beats.size() == 0)
            begin
                n_errors++;
                if (n_shown < 10)
                begin
                    n_shown++;
                    $display("unexpected result beat: pos %0d char %h st %0d cnt %0d last %0b",
                        got.position, got.character, got.status_code, got.changed_count,
                        got.last_result);
                end
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_shown < 10)
                    begin
                        n_shown++;
                        $display("mismatch: expected pos %0d char %h st %0d cnt %0d last %0b",
                            want.position, want.character, want.status_code,
                            want.changed_count, want.last_result);
                        $display("          actual   pos %0d char %h st %0d cnt %0d last %0b",
                            got.position, got.character, got.status_code,
                            got.changed_count, got.last_result);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_basic_states();
        send_beat(ppe_pkg::OP_NEXT, 8'h00);     // next with nothing loaded
        send_beat(OP_UNUSED, 8'hFF);            // unused op: ignored
        send_text("a");
        send_beat(ppe_pkg::OP_END, 8'h00);
        send_beat(ppe_pkg::OP_NEXT, 8'h00);     // single literal, exhausted at once
        send_beat(ppe_pkg::OP_NEXT, 8'h00);     // exhaustion repeats
        send_beat(ppe_pkg::OP_END, 8'h00);      // end while loaded: too few
        send_beat(ppe_pkg::OP_BYTE, 8'hFF);
        send_beat(ppe_pkg::OP_END, 8'h00);
        send_beat(ppe_pkg::OP_BYTE, 8'h00);
        send_beat(ppe_pkg::OP_END, 8'h00);
    endtask

    task automatic test_parse_errors();
        write_length(5'd3);
        send_text("[ab");
        send_beat(ppe_pkg::OP_END, 8'h00);      // unclosed set
        send_text("[-a]..");
        send_beat(ppe_pkg::OP_END, 8'h00);      // dash without start
        send_text("ab");
        send_beat(ppe_pkg::OP_END, 8'h00);      // too few
        send_text("abcd");
        send_beat(ppe_pkg::OP_END, 8'h00);      // too many
        send_text("[");
        send_beat(ppe_pkg::OP_BYTE, 8'h00);
        send_text("-");
        send_beat(ppe_pkg::OP_BYTE, 8'hFF);
        send_text("]bc");
        send_beat(ppe_pkg::OP_END, 8'h00);      // 256 chars: set overflow
    endtask

    task automatic test_sets_and_ranges();
        int i;
        write_length(5'd3);
        send_text("[z-x][q-q][]");              // descending, equal ends, empty set
        send_beat(ppe_pkg::OP_END, 8'h00);
        for (i = 0; i < 4; i++) send_beat(ppe_pkg::OP_NEXT, 8'h00);
        send_text(".[a-c-a]-");                 // dot, chained ranges, bare dash literal
        send_beat(ppe_pkg::OP_END, 8'h00);
        for (i = 0; i < 8; i++) send_beat(ppe_pkg::OP_NEXT, 8'h00);
    endtask

    task automatic test_length_extremes();
        int i;
        write_length(5'd0);                     // counts as one position
        send_text("[xy]");
        send_beat(ppe_pkg::OP_END, 8'h00);
        for (i = 0; i < 3; i++) send_beat(ppe_pkg::OP_NEXT, 8'h00);
        write_length(5'd31);                    // clipped to sixteen
        for (i = 0; i < 15; i++) send_text("[01]");
        send_text("[ab]");
        send_beat(ppe_pkg::OP_END, 8'h00);
        for (i = 0; i < 20; i++) send_beat(ppe_pkg::OP_NEXT, 8'h00);
        write_length(5'd16);
        send_text("0123456789abcdef");
        send_beat(ppe_pkg::OP_END, 8'h00);
        send_beat(ppe_pkg::OP_NEXT, 8'h00);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == ppe_pkg::CH_OPEN || c == ppe_pkg::CH_CLOSE ||
               c == ppe_pkg::CH_DASH || c == ppe_pkg::CH_DOT);
        return c;
    endfunction

    // well-formed patterns with random content, plus noise and broken ones
    task automatic test_random_patterns(int n_items);
        int sent;
        int n;
        int p;
        int j;
        int k;
        logic [7:0] c;
        sent = 0;
        while (sent < n_items)
        begin
            if (sent > n_items * 3 / 4) quiet = 1'b1;
            n = $urandom_range(1, 4);
            if ($urandom_range(0, 15) == 0) n = $urandom_range(1, 16);
            write_length(5'(n));
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any op, any byte
                repeat ($urandom_range(1, 6))
                begin
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    sent++;
                end
                continue;
            end
            // a broken pattern now and then defines one position more or less
            k = n;
            if ($urandom_range(0, 7) == 0) k = n + ($urandom_range(0, 1) ? 1 : -1);
            for (p = 0; p < k; p++)
            begin
                j = $urandom_range(0, 9);
                if (j < 4)
                    send_beat(ppe_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
                else if (j == 4 && n <= 2)
                    send_beat(ppe_pkg::OP_BYTE, ppe_pkg::CH_DOT);
                else
                begin
                    send_beat(ppe_pkg::OP_BYTE, ppe_pkg::CH_OPEN);
                    repeat ($urandom_range(0, 3))
                    begin
                        c = plain_char();
                        send_beat(ppe_pkg::OP_BYTE, c);
                        if ($urandom_range(0, 2) == 0)
                        begin
                            send_beat(ppe_pkg::OP_BYTE, ppe_pkg::CH_DASH);
                            send_beat(ppe_pkg::OP_BYTE,
                                      8'(int'(c) + $urandom_range(0, 8) - 4));
                            sent += 2;
                        end
                        sent++;
                    end
                    if ($urandom_range(0, 15) != 0)
                        send_beat(ppe_pkg::OP_BYTE, ppe_pkg::CH_CLOSE);
                    sent++;
                end
                sent++;
            end
            send_beat(ppe_pkg::OP_END, 8'h00);
            sent++;
            repeat ($urandom_range(0, 12))
            begin
                send_beat(ppe_pkg::OP_NEXT, 8'h00);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.operation = ppe_pkg::OP_BYTE;
        cmd.pattern_byte = '0;
        result.ready = 1'b0;
        quiet = 1'b0;
        cycles = 0;
        n_errors = 0;
        n_shown = 0;
        cmd_gap_left = 0;
        stall_left = 0;
        sh_len_reg = 5'd1;
        sh_loaded = 1'b0;
        sh_exhausted = 1'b0;
        reset_parser();
        for (int p = 0; p < ppe_pkg::LEN_CAP; p++)
        begin
            sh_size[p] = 0;
            sh_idx[p] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_states();
        test_parse_errors();
        test_sets_and_ranges();
        test_length_extremes();
        test_random_patterns(70);

        wait_idle();
        if (n_errors == 0 && expected_beats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
